FILE: sv/acrm_pkg.sv
// ----------------------------------------------------------------------------
// acrm_pkg: shared types and constants for the ARP cache
// Entry layout, header check constants and result status codes.
// ----------------------------------------------------------------------------
package acrm_pkg;

    localparam int CACHE_ENTRIES = 8;
    localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

    localparam logic [15:0] ARP_MIN_LEN = 16'd28;
    localparam logic [15:0] HW_ETHERNET = 16'h0001;
    localparam logic [15:0] PROTO_IPV4  = 16'h0800;
    localparam logic [15:0] OP_REPLY    = 16'h0002;

    localparam logic [2:0] ST_HIT      = 3'd0;
    localparam logic [2:0] ST_MISS     = 3'd1;
    localparam logic [2:0] ST_DROP     = 3'd2;
    localparam logic [2:0] ST_CACHED   = 3'd3;
    localparam logic [2:0] ST_RESOLVED = 3'd4;

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_PACKET = 1'b1;

    typedef struct packed {
        logic [31:0] ip;
        logic [47:0] mac;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

FILE: sv/acrm_ram.sv
// ----------------------------------------------------------------------------
// acrm_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents not reset.
// ----------------------------------------------------------------------------
module acrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/arp_cache_with_reply_match_top.sv
// ----------------------------------------------------------------------------
// arp_cache_with_reply_match_top: ARP cache with one pending-resolve slot
// Lookup and received-packet commands against a small IPv4-to-MAC table
// held in RAM; a linear scan sequencer does the search and the update.
// ----------------------------------------------------------------------------
//
//  channel | signals                                   | dir | transfer when
//  --------+-------------------------------------------+-----+------------------------
//  in      | in_valid/in_ready, command..src_ip        | in  | in_valid && in_ready
//  out     | out_valid/out_ready, status, mac_result   | out | out_valid && out_ready
//
//  Sequencing: one command at a time. A dropped packet goes from S_IDLE
//  straight to S_FINISH and the result register. Otherwise the scan walks
//  entries from 0: a valid entry takes a RAM read (S_READ) and a compare
//  (S_CMP), an empty one only S_READ; then the update step (S_MISS) and
//  the result step (S_FINISH). A hit stops the scan early and skips S_MISS.
//  Reset: valid bits, pending slot and control clear at once; RAM contents
//  are never read until written, so no clearing pass.
//  Stalls: in_ready is high whenever the sequencer is idle, even while a
//  result waits in the output register; a new result waits for that
//  register to drain.
//
module arp_cache_with_reply_match_top
    import acrm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        command,
    input  logic [31:0] lookup_ip,
    input  logic [15:0] arp_len,
    input  logic [15:0] hw_type,
    input  logic [15:0] ptype,
    input  logic [15:0] opcode,
    input  logic [47:0] src_mac,
    input  logic [31:0] src_ip,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [47:0] mac_result
);

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_READ   = 3'd1;  // read slot idx, or skip if empty
    localparam logic [2:0] S_CMP    = 3'd2;  // RAM data for idx is valid
    localparam logic [2:0] S_MISS   = 3'd3;  // scan done, no match
    localparam logic [2:0] S_FINISH = 3'd4;  // hand result to output register

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CACHE_ENTRIES - 1);

    logic [2:0]               state_reg, state_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic                     free_found_reg, free_found_next;
    logic [IDX_W-1:0]         free_idx_reg, free_idx_next;
    logic [CACHE_ENTRIES-1:0] valid_reg, valid_next;
    logic [31:0]              pending_addr_reg, pending_addr_next;
    logic [47:0]              pending_hw_reg, pending_hw_next;
    logic                     pending_done_reg, pending_done_next;
    logic                     out_valid_reg, out_valid_next;

    // latched command and working result (no reset needed)
    logic                     cmd_reg, cmd_next;
    logic [31:0]              key_ip_reg, key_ip_next;
    logic [47:0]              mac_in_reg, mac_in_next;
    logic                     is_reply_reg, is_reply_next;
    logic [2:0]               sts_reg, sts_next;
    logic [47:0]              res_mac_reg, res_mac_next;
    logic [2:0]               out_status_reg, out_status_next;
    logic [47:0]              out_mac_reg, out_mac_next;

    // RAM port
    logic                     ram_we;
    logic [IDX_W-1:0]         ram_waddr;
    entry_t                   ram_wdata;
    entry_t                   ram_rdata;
    logic [ENTRY_W-1:0]       ram_rdata_raw;

    logic                     in_xfer;
    logic                     drop;
    logic                     reply_match;

    acrm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CACHE_ENTRIES),
        .AW    (IDX_W)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata_raw)
    );

    assign ram_rdata = entry_t'(ram_rdata_raw);

    assign in_ready = (state_reg == S_IDLE);
    assign in_xfer  = in_valid && in_ready;

    // header filter for received packets
    assign drop = (arp_len < ARP_MIN_LEN) || (hw_type != HW_ETHERNET) ||
                  (ptype != PROTO_IPV4);

    // pending address is stable for the whole packet command
    assign reply_match = is_reply_reg && (key_ip_reg == pending_addr_reg);

    always_comb
    begin
        state_next        = state_reg;
        idx_next          = idx_reg;
        free_found_next   = free_found_reg;
        free_idx_next     = free_idx_reg;
        valid_next        = valid_reg;
        pending_addr_next = pending_addr_reg;
        pending_hw_next   = pending_hw_reg;
        pending_done_next = pending_done_reg;
        out_valid_next    = out_valid_reg;
        cmd_next          = cmd_reg;
        key_ip_next       = key_ip_reg;
        mac_in_next       = mac_in_reg;
        is_reply_next     = is_reply_reg;
        sts_next          = sts_reg;
        res_mac_next      = res_mac_reg;
        out_status_next   = out_status_reg;
        out_mac_next      = out_mac_reg;
        ram_we            = 1'b0;
        ram_waddr         = idx_reg;
        ram_wdata         = '{ip: key_ip_reg, mac: mac_in_reg};

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    cmd_next        = command;
                    key_ip_next     = (command == CMD_LOOKUP) ? lookup_ip : src_ip;
                    mac_in_next     = src_mac;
                    is_reply_next   = (opcode == OP_REPLY);
                    idx_next        = '0;
                    free_found_next = 1'b0;
                    free_idx_next   = '0;
                    res_mac_next    = '0;
                    if (command == CMD_PACKET && drop)
                    begin
                        sts_next   = ST_DROP;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                if (valid_reg[idx_reg])
                begin
                    state_next = S_CMP;
                end
                else
                begin
                    // remember first empty slot for insertion
                    if (!free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = idx_reg;
                    end
                    if (idx_reg == IDX_LAST)
                    begin
                        state_next = S_MISS;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            S_CMP:
            begin
                if (ram_rdata.ip == key_ip_reg)
                begin
                    state_next = S_FINISH;
                    if (cmd_reg == CMD_LOOKUP)
                    begin
                        sts_next     = ST_HIT;
                        res_mac_next = ram_rdata.mac;
                    end
                    else
                    begin
                        // duplicate sender: refresh MAC in place
                        ram_we    = 1'b1;
                        ram_waddr = idx_reg;
                        if (reply_match)
                        begin
                            pending_hw_next   = mac_in_reg;
                            pending_done_next = 1'b1;
                            sts_next          = ST_RESOLVED;
                        end
                        else
                        begin
                            sts_next = ST_CACHED;
                        end
                    end
                end
                else if (idx_reg == IDX_LAST)
                begin
                    state_next = S_MISS;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_READ;
                end
            end
            S_MISS:
            begin
                state_next = S_FINISH;
                if (cmd_reg == CMD_LOOKUP)
                begin
                    pending_addr_next = key_ip_reg;
                    pending_done_next = 1'b0;
                    sts_next          = ST_MISS;
                end
                else
                begin
                    // first empty slot, else evict slot 0
                    ram_we    = 1'b1;
                    ram_waddr = free_found_reg ? free_idx_reg : '0;
                    valid_next[ram_waddr] = 1'b1;
                    if (reply_match)
                    begin
                        pending_hw_next   = mac_in_reg;
                        pending_done_next = 1'b1;
                        sts_next          = ST_RESOLVED;
                    end
                    else
                    begin
                        sts_next = ST_CACHED;
                    end
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = sts_reg;
                    out_mac_next    = (sts_reg == ST_RESOLVED) ? pending_hw_reg : res_mac_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            idx_reg          <= '0;
            free_found_reg   <= 1'b0;
            free_idx_reg     <= '0;
            valid_reg        <= '0;
            pending_addr_reg <= '0;
            pending_hw_reg   <= '0;
            pending_done_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            idx_reg          <= idx_next;
            free_found_reg   <= free_found_next;
            free_idx_reg     <= free_idx_next;
            valid_reg        <= valid_next;
            pending_addr_reg <= pending_addr_next;
            pending_hw_reg   <= pending_hw_next;
            pending_done_reg <= pending_done_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        key_ip_reg     <= key_ip_next;
        mac_in_reg     <= mac_in_next;
        is_reply_reg   <= is_reply_next;
        sts_reg        <= sts_next;
        res_mac_reg    <= res_mac_next;
        out_status_reg <= out_status_next;
        out_mac_reg    <= out_mac_next;
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign mac_result = out_mac_reg;

    // only packet commands write the table
    a_write_on_packet: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (cmd_reg == CMD_PACKET))
        else $error("table write during lookup");

    // a written slot is valid afterwards
    a_write_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> valid_reg[$past(ram_waddr)])
        else $error("written slot not marked valid");

    // compare only follows a read of a valid slot
    a_cmp_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> valid_reg[idx_reg])
        else $error("compare on empty slot");

    // a resolved result comes with the pending slot marked done
    a_resolved_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && sts_reg == ST_RESOLVED) |-> pending_done_reg)
        else $error("resolved without pending done");

    // lookup misses, drops and cached packets carry a zero MAC
    a_zero_mac: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg == ST_MISS || out_status_reg == ST_DROP ||
                           out_status_reg == ST_CACHED)) |-> (out_mac_reg == '0))
        else $error("nonzero MAC on non-hit result");

endmodule

FILE: dv/arp_cache_with_reply_match_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_cache_with_reply_match_top_test: self-checking bench for the ARP cache
// Drives lookup and packet commands with bursty valid and a stalling ready,
// predicts every result from a local copy of cache and pending slot, and
// compares status and MAC of each result transfer in order.
// ----------------------------------------------------------------------------
module arp_cache_with_reply_match_top_test;

    import acrm_pkg::*;

    localparam int NUM_RANDOM     = 550;
    localparam int WATCHDOG_LIMIT = 4000;  // idle cycles; longer than LONG_HOLD
    localparam int LONG_HOLD      = 400;
    localparam int TAIL_CYCLES    = 40;    // > worst-case command latency
    localparam int POOL_SIZE      = 12;    // more than CACHE_ENTRIES, forces eviction

    // one command as seen on the input channel
    typedef struct {
        logic        command;
        logic [31:0] lookup_ip;
        logic [15:0] arp_len;
        logic [15:0] hw_type;
        logic [15:0] ptype;
        logic [15:0] opcode;
        logic [47:0] src_mac;
        logic [31:0] src_ip;
    } arp_cmd_t;

    // one result as seen on the output channel
    typedef struct {
        logic [2:0]  status;
        logic [47:0] mac;
    } arp_reply_t;

    // ------------------------------------------------------------------------
    // Scoreboard: shadow cache plus queue of predicted replies
    // ------------------------------------------------------------------------
    class arp_cache_scoreboard;
        logic [31:0] cache_ip  [CACHE_ENTRIES];
        logic [47:0] cache_mac [CACHE_ENTRIES];
        bit          cache_vld [CACHE_ENTRIES];
        logic [31:0] pend_ip;
        logic [47:0] pend_mac;
        bit          pend_done;
        arp_reply_t  expected_replies[$];
        int          errors;

        function new();
            for (int i = 0; i < CACHE_ENTRIES; i++)
            begin
                cache_vld[i] = 1'b0;
            end
            pend_ip   = '0;
            pend_mac  = '0;
            pend_done = 1'b0;
            errors    = 0;
        endfunction

        function int outstanding();
            return expected_replies.size();
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 100)
            begin
                $display("%0t ERROR: %s", $time, msg);
            end
        endtask

        function int find_slot(logic [31:0] ip);
            for (int i = 0; i < CACHE_ENTRIES; i++)
            begin
                if (cache_vld[i] && cache_ip[i] == ip)
                begin
                    return i;
                end
            end
            return -1;
        endfunction

        // update existing entry, else first free slot, else evict slot 0
        function void learn_sender(logic [31:0] ip, logic [47:0] mac);
            int slot;
            slot = find_slot(ip);
            if (slot >= 0)
            begin
                cache_mac[slot] = mac;
                return;
            end
            slot = 0;
            for (int i = 0; i < CACHE_ENTRIES; i++)
            begin
                if (!cache_vld[i])
                begin
                    slot = i;
                    break;
                end
            end
            cache_ip[slot]  = ip;
            cache_mac[slot] = mac;
            cache_vld[slot] = 1'b1;
        endfunction

        // called on every input transfer
        function void note_command(arp_cmd_t c);
            arp_reply_t r;
            int         slot;
            r.mac = '0;
            if (c.command == CMD_LOOKUP)
            begin
                slot = find_slot(c.lookup_ip);
                if (slot >= 0)
                begin
                    r.status = ST_HIT;
                    r.mac    = cache_mac[slot];
                end
                else
                begin
                    r.status  = ST_MISS;
                    pend_ip   = c.lookup_ip;
                    pend_done = 1'b0;
                end
            end
            else if (c.arp_len < ARP_MIN_LEN || c.hw_type != HW_ETHERNET ||
                     c.ptype != PROTO_IPV4)
            begin
                r.status = ST_DROP;
            end
            else
            begin
                // insertion always precedes the reply match
                learn_sender(c.src_ip, c.src_mac);
                if (c.opcode == OP_REPLY && c.src_ip == pend_ip)
                begin
                    pend_mac  = c.src_mac;
                    pend_done = 1'b1;
                    r.status  = ST_RESOLVED;
                    r.mac     = c.src_mac;
                end
                else
                begin
                    r.status = ST_CACHED;
                end
            end
            expected_replies.push_back(r);
        endfunction

        // called on every output transfer
        task check_reply(logic [2:0] st, logic [47:0] mac);
            arp_reply_t e;
            if (expected_replies.size() == 0)
            begin
                report($sformatf("unexpected result status=%0d mac=%h", st, mac));
                return;
            end
            e = expected_replies.pop_front();
            if (st !== e.status)
            begin
                report($sformatf("status got %0d exp %0d", st, e.status));
            end
            if (mac !== e.mac)
            begin
                report($sformatf("mac_result got %h exp %h", mac, e.mac));
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // DUT signals; every bench-driven signal starts at a known value
    // ------------------------------------------------------------------------
    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_ready;
    logic        command     = 1'b0;
    logic [31:0] lookup_ip   = '0;
    logic [15:0] arp_len     = '0;
    logic [15:0] hw_type     = '0;
    logic [15:0] ptype       = '0;
    logic [15:0] opcode      = '0;
    logic [47:0] src_mac     = '0;
    logic [31:0] src_ip      = '0;
    logic        out_valid;
    logic        out_ready   = 1'b0;
    logic [2:0]  status;
    logic [47:0] mac_result;

    arp_cache_scoreboard sb = new();

    logic [31:0] ip_pool [POOL_SIZE];
    logic [31:0] last_target = '0;   // most recent lookup address
    bit          hold_req    = 1'b0; // asks the receiver for a long hold-off
    int          idle_cycles = 0;

    arp_cache_with_reply_match_top i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .lookup_ip   (lookup_ip),
        .arp_len     (arp_len),
        .hw_type     (hw_type),
        .ptype       (ptype),
        .opcode      (opcode),
        .src_mac     (src_mac),
        .src_ip      (src_ip),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .mac_result  (mac_result)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------------
    // Item builders
    // ------------------------------------------------------------------------
    function automatic logic [47:0] rand_mac();
        return 48'({$urandom(), $urandom()});
    endfunction

    // lookup; packet fields carry noise since the block must ignore them
    function automatic arp_cmd_t make_lookup(logic [31:0] ip);
        arp_cmd_t c;
        c.command   = CMD_LOOKUP;
        c.lookup_ip = ip;
        c.arp_len   = 16'($urandom());
        c.hw_type   = 16'($urandom());
        c.ptype     = 16'($urandom());
        c.opcode    = 16'($urandom());
        c.src_mac   = rand_mac();
        c.src_ip    = $urandom();
        return c;
    endfunction

    // packet; lookup_ip carries noise
    function automatic arp_cmd_t make_packet(logic [15:0] len, logic [15:0] hw,
                                             logic [15:0] proto, logic [15:0] op,
                                             logic [47:0] mac, logic [31:0] ip);
        arp_cmd_t c;
        c.command   = CMD_PACKET;
        c.lookup_ip = $urandom();
        c.arp_len   = len;
        c.hw_type   = hw;
        c.ptype     = proto;
        c.opcode    = op;
        c.src_mac   = mac;
        c.src_ip    = ip;
        return c;
    endfunction

    // address mix: mostly the small pool so hits, duplicates and eviction
    // happen often; sometimes the pending address so replies resolve
    function automatic logic [31:0] pick_ip();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return ip_pool[$urandom_range(0, POOL_SIZE - 1)];
        end
        else if (r < 72)
        begin
            return last_target;
        end
        return $urandom();
    endfunction

    function automatic arp_cmd_t rand_cmd();
        int          r;
        logic [15:0] len;
        logic [15:0] op;
        r = $urandom_range(0, 99);
        if (r < 42)
        begin
            return make_lookup(pick_ip());
        end
        else if (r < 88)
        begin
            // well-formed packet, mostly replies
            len = ($urandom_range(0, 2) == 0) ? ARP_MIN_LEN : 16'($urandom_range(28, 65535));
            op  = ($urandom_range(0, 9) < 6) ? OP_REPLY : 16'($urandom());
            return make_packet(len, HW_ETHERNET, PROTO_IPV4, op, rand_mac(), pick_ip());
        end
        // broken packet: random header, often a near miss on one check
        case ($urandom_range(0, 3))
            0:       return make_packet(16'($urandom_range(0, 27)), HW_ETHERNET,
                                        PROTO_IPV4, OP_REPLY, rand_mac(), pick_ip());
            1:       return make_packet(16'($urandom()), 16'($urandom()), PROTO_IPV4,
                                        OP_REPLY, rand_mac(), pick_ip());
            2:       return make_packet(16'($urandom()), HW_ETHERNET, 16'($urandom()),
                                        OP_REPLY, rand_mac(), pick_ip());
            default: return make_packet(16'($urandom()), 16'($urandom()),
                                        16'($urandom()), 16'($urandom()),
                                        rand_mac(), $urandom());
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Driver tasks; called at a rising edge, return at the transfer edge
    // ------------------------------------------------------------------------
    task automatic send_cmd(arp_cmd_t c);
        command   <= c.command;
        lookup_ip <= c.lookup_ip;
        arp_len   <= c.arp_len;
        hw_type   <= c.hw_type;
        ptype     <= c.ptype;
        opcode    <= c.opcode;
        src_mac   <= c.src_mac;
        src_ip    <= c.src_ip;
        in_valid  <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        if (c.command == CMD_LOOKUP)
        begin
            last_target = c.lookup_ip;
        end
        sb.note_command(c);
    endtask

    // stop offering until every predicted reply has come back
    task automatic drain_replies();
        in_valid <= 1'b0;
        while (sb.outstanding() > 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random ready modes, plus one long hold-off on request
    // ------------------------------------------------------------------------
    int rx_hold_left = 0;
    int rx_mode      = 0;
    int rx_mode_left = 0;

    always @(posedge clk)
    begin
        if (rx_hold_left > 0)
        begin
            out_ready    <= 1'b0;
            rx_hold_left--;
        end
        else if (hold_req)
        begin
            hold_req     = 1'b0;
            rx_hold_left = LONG_HOLD;
            out_ready    <= 1'b0;
        end
        else
        begin
            if (rx_mode_left == 0)
            begin
                rx_mode      = $urandom_range(0, 3);
                rx_mode_left = $urandom_range(5, 120);
            end
            rx_mode_left--;
            case (rx_mode)
                0:       out_ready <= 1'b1;                        // no stall
                1:       out_ready <= ($urandom_range(0, 1) == 0);
                2:       out_ready <= ($urandom_range(0, 3) == 0); // heavy stall
                default: out_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            sb.check_reply(status, mac_result);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: ends the run if no transfer happens for too long
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t ERROR: watchdog, no transfer in %0d cycles", $time,
                         WATCHDOG_LIMIT);
                $display("arp_cache_with_reply_match_top_test: FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        int burst_left;
        int gap;

        for (int i = 0; i < POOL_SIZE; i++)
        begin
            ip_pool[i] = $urandom();
        end
        ip_pool[0] = 32'h0000_0000;
        ip_pool[1] = 32'hFFFF_FFFF;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed part ---
        // reply from address 0 right after reset: pending slot resolves unarmed
        send_cmd(make_packet(ARP_MIN_LEN, HW_ETHERNET, PROTO_IPV4, OP_REPLY,
                             48'hFFFF_FFFF_FFFF, 32'h0000_0000));
        send_cmd(make_lookup(32'h0000_0000));                      // hit
        // miss with all-ones noise on the packet fields
        begin
            arp_cmd_t c;
            c = make_lookup(32'hFFFF_FFFF);
            c.arp_len = '1;
            c.hw_type = '1;
            c.ptype   = '1;
            c.opcode  = '1;
            c.src_mac = '1;
            c.src_ip  = '1;
            send_cmd(c);
        end
        // resolve, then repeated resolve on the same duplicate sender
        send_cmd(make_packet(16'hFFFF, HW_ETHERNET, PROTO_IPV4, OP_REPLY,
                             48'h0, 32'hFFFF_FFFF));
        send_cmd(make_packet(16'd29, HW_ETHERNET, PROTO_IPV4, OP_REPLY,
                             rand_mac(), 32'hFFFF_FFFF));
        send_cmd(make_lookup(32'hFFFF_FFFF));                      // hit, new MAC
        // drops: short, zero length, bad hardware type, bad protocol type
        send_cmd(make_packet(16'd27, HW_ETHERNET, PROTO_IPV4, OP_REPLY,
                             rand_mac(), 32'hFFFF_FFFF));
        send_cmd(make_packet(16'd0, HW_ETHERNET, PROTO_IPV4, OP_REPLY,
                             rand_mac(), 32'h1));
        send_cmd(make_packet(ARP_MIN_LEN, 16'h0000, PROTO_IPV4, OP_REPLY,
                             rand_mac(), 32'h2));
        send_cmd(make_packet(ARP_MIN_LEN, 16'hFFFF, PROTO_IPV4, OP_REPLY,
                             rand_mac(), 32'h3));
        send_cmd(make_packet(ARP_MIN_LEN, HW_ETHERNET, 16'h0806, OP_REPLY,
                             rand_mac(), 32'h4));
        // non-reply opcodes are cached but unmatched
        send_cmd(make_packet(ARP_MIN_LEN, HW_ETHERNET, PROTO_IPV4, 16'h0001,
                             rand_mac(), 32'h0A00_0001));
        send_cmd(make_packet(ARP_MIN_LEN, HW_ETHERNET, PROTO_IPV4, 16'hFFFF,
                             rand_mac(), 32'h0A00_0002));
        // fill the remaining slots, the last two inserts evict slot 0
        for (int k = 0; k < 6; k++)
        begin
            send_cmd(make_packet(ARP_MIN_LEN, HW_ETHERNET, PROTO_IPV4, 16'h0001,
                                 rand_mac(), 32'hC0A8_0000 + k));
        end
        send_cmd(make_lookup(32'h0000_0000));                      // evicted: miss
        send_cmd(make_lookup(32'hC0A8_0005));                      // hit
        drain_replies();

        // --- random part ---
        burst_left = 0;
        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            // receiver holds off while the sender keeps offering
            if (n == 150)
            begin
                hold_req = 1'b1;
            end
            // sender waits for the block to empty out completely
            if (n == 350)
            begin
                drain_replies();
            end
            if (burst_left == 0)
            begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
                if (gap > 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                burst_left = $urandom_range(1, 40);
            end
            send_cmd(rand_cmd());
            burst_left--;
        end

        // --- end of run ---
        in_valid <= 1'b0;
        while (sb.outstanding() > 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.outstanding() != 0)
        begin
            sb.report($sformatf("%0d results never arrived", sb.outstanding()));
        end
        if (sb.errors == 0)
        begin
            $display("arp_cache_with_reply_match_top_test: PASS");
        end
        else
        begin
            $display("arp_cache_with_reply_match_top_test: FAIL");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/acrm_pkg.sv
sv/acrm_ram.sv
sv/arp_cache_with_reply_match_top.sv
dv/arp_cache_with_reply_match_top_test.sv
